>>> hw/rtl/rct_pkg.sv
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types, codes and sizes of the reply completion tracker.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int TYPE_SLOTS = 16;
  localparam int SOURCES    = 64;
  localparam int TYPE_BITS  = $clog2(TYPE_SLOTS);
  localparam int SRC_BITS   = $clog2(SOURCES);
  localparam int CNT_BITS   = SRC_BITS + 1;
  localparam int ADDR_BITS  = TYPE_BITS + SRC_BITS;
  localparam int DEPTH      = TYPE_SLOTS * SOURCES;

  localparam logic [2:0] MODE_REPLY  = 3'd0;
  localparam logic [2:0] MODE_ADD    = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_QUERY  = 3'd3;
  localparam logic [2:0] MODE_LOAD   = 3'd4;

  localparam logic [1:0] KIND_ANY     = 2'd0;
  localparam logic [1:0] KIND_EACH    = 2'd1;
  localparam logic [1:0] KIND_NTIMES  = 2'd2;
  localparam logic [1:0] KIND_GENERAL = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  type_index;
    logic [5:0]  source_index;
    logic [1:0]  kind;
    logic [15:0] count;
    logic        spawn;
  } in_t;

  typedef struct packed {
    logic accepted;
    logic fired;
    logic spawn_thread;
    logic ready_res;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [7:0]           wdata;
    logic [ADDR_BITS-1:0] raddr;
  } cnt_port_t;

endpackage

>>> hw/rtl/rct_count_ram.sv
// ----------------------------------------------------------------------------
// rct_count_ram
// Per-type, per-source count memory with one write and one registered read.
// ----------------------------------------------------------------------------
module rct_count_ram (
  input  logic              clk,
  input  rct_pkg::cnt_port_t port_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [rct_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (port_i.we) begin
      mem[port_i.waddr] <= port_i.wdata;
    end
    rdata_o <= mem[port_i.raddr];
  end

endmodule

>>> hw/rtl/rct_ctrl.sv
// ----------------------------------------------------------------------------
// rct_ctrl
// Entry table, clearing pass, item execution and the reload sweep of the remaining counts.
// ----------------------------------------------------------------------------
module rct_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept_i,
  input  rct_pkg::in_t       in_i,
  input  logic [7:0]         exp_rdata_i,
  input  logic [7:0]         rem_rdata_i,
  output rct_pkg::cnt_port_t exp_o,
  output rct_pkg::cnt_port_t rem_o,
  output rct_pkg::res_t      res_o,
  output logic               idle_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_SWEEP = 4'b1000
  } state_t;

  localparam int NT = rct_pkg::TYPE_SLOTS;
  localparam int CB = rct_pkg::CNT_BITS;
  localparam int SB = rct_pkg::SRC_BITS;

  state_t                         state_r, state_nxt;
  rct_pkg::in_t                   q_r;
  logic [rct_pkg::ADDR_BITS-1:0]  clr_r;
  logic [CB-1:0]                  sw_r;
  logic [CB-1:0]                  pacc_r;
  logic [NT-1:0]                  valid_r;
  logic [1:0]                     kind_r   [NT];
  logic                           spawn_r  [NT];
  logic [15:0]                    thr_r    [NT];
  logic [rct_pkg::SOURCES-1:0]    mask_r   [NT];
  logic [15:0]                    rc_r     [NT];
  logic [CB-1:0]                  pend_r   [NT];

  logic [rct_pkg::TYPE_BITS-1:0]  t;
  logic [SB-1:0]                  s;
  logic                           live;
  logic [CB-1:0]                  lim;
  logic [rct_pkg::SOURCES-1:0]    full;
  logic [rct_pkg::SOURCES-1:0]    mask_new;
  logic [16:0]                    rc_inc;
  logic [7:0]                     rem_dec;
  logic [CB-1:0]                  pend_new;
  logic                           fire;
  logic                           do_sweep;
  logic                           rem_nz;
  logic                           sweep_end;

  always_comb begin
    t        = q_r.type_index;
    s        = q_r.source_index;
    live     = valid_r[t];
    lim      = (thr_r[t] > 16'(rct_pkg::SOURCES)) ? CB'(rct_pkg::SOURCES) : thr_r[t][CB-1:0];
    full     = ~({rct_pkg::SOURCES{1'b1}} << lim);
    mask_new = mask_r[t] | (rct_pkg::SOURCES'(1) << s);
    rc_inc   = {1'b0, rc_r[t]} + 17'd1;
    rem_dec  = rem_rdata_i - 8'd1;
    pend_new = pend_r[t];
    if (rem_rdata_i != 8'd0 && rem_dec == 8'd0 && pend_r[t] != '0) begin
      pend_new = pend_r[t] - CB'(1);
    end
    fire = 1'b0;
    case (kind_r[t])
      rct_pkg::KIND_ANY:    fire = 1'b1;
      rct_pkg::KIND_EACH:   fire = ({1'b0, s} < lim) && (mask_new == full);
      rct_pkg::KIND_NTIMES: fire = rc_inc >= {1'b0, thr_r[t]};
      default:              fire = (pend_new == '0);
    endcase
    do_sweep = 1'b0;
    if (q_r.mode == rct_pkg::MODE_REPLY && live && fire &&
        kind_r[t] == rct_pkg::KIND_GENERAL) begin
      do_sweep = 1'b1;
    end
    if (q_r.mode == rct_pkg::MODE_ADD && !live && q_r.kind == rct_pkg::KIND_GENERAL) begin
      do_sweep = 1'b1;
    end
    rem_nz    = (exp_rdata_i != 8'd0);
    sweep_end = (sw_r == CB'(rct_pkg::SOURCES));
  end

  always_comb begin
    res_o       = '0;
    res_o.valid = (state_r == ST_EXEC);
    case (q_r.mode)
      rct_pkg::MODE_REPLY: begin
        res_o.data.accepted     = live;
        res_o.data.fired        = live && fire;
        res_o.data.spawn_thread = live && fire && spawn_r[t];
      end
      rct_pkg::MODE_ADD:    res_o.data.accepted = !live;
      rct_pkg::MODE_REMOVE: res_o.data.accepted = live;
      rct_pkg::MODE_QUERY: begin
        res_o.data.accepted = live;
        case (kind_r[t])
          rct_pkg::KIND_EACH:    res_o.data.ready_res = live && (mask_r[t] == full);
          rct_pkg::KIND_NTIMES:  res_o.data.ready_res = live && (rc_r[t] == thr_r[t]);
          rct_pkg::KIND_GENERAL: res_o.data.ready_res = live && (pend_r[t] == '0);
          default:               res_o.data.ready_res = 1'b0;
        endcase
      end
      rct_pkg::MODE_LOAD:   res_o.data.accepted = 1'b1;
      default:              res_o.data = '0;
    endcase
  end

  always_comb begin
    exp_o       = '0;
    exp_o.raddr = {t, sw_r[SB-1:0]};
    if (state_r == ST_CLEAR) begin
      exp_o.we    = 1'b1;
      exp_o.waddr = clr_r;
    end else if (state_r == ST_EXEC && q_r.mode == rct_pkg::MODE_LOAD) begin
      exp_o.we    = 1'b1;
      exp_o.waddr = {t, s};
      exp_o.wdata = (q_r.count[15:8] != 8'd0) ? 8'hFF : q_r.count[7:0];
    end
    rem_o       = '0;
    rem_o.raddr = {in_i.type_index, in_i.source_index};
    if (state_r == ST_SWEEP && sw_r != '0) begin
      rem_o.we    = 1'b1;
      rem_o.waddr = {t, sw_r[SB-1:0] - SB'(1)};
      rem_o.wdata = exp_rdata_i;
    end else if (state_r == ST_EXEC && q_r.mode == rct_pkg::MODE_REPLY && live &&
                 kind_r[t] == rct_pkg::KIND_GENERAL && rem_rdata_i != 8'd0) begin
      rem_o.we    = 1'b1;
      rem_o.waddr = {t, s};
      rem_o.wdata = rem_dec;
    end
  end

  assign idle_o = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == rct_pkg::ADDR_BITS'(rct_pkg::DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept_i) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = do_sweep ? ST_SWEEP : ST_IDLE;
      ST_SWEEP: if (sweep_end) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      valid_r <= '0;
      for (int i = 0; i < NT; i++) begin
        mask_r[i] <= '0;
        rc_r[i]   <= '0;
        pend_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + rct_pkg::ADDR_BITS'(1);
      end
      if (state_r == ST_EXEC) begin
        case (q_r.mode)
          rct_pkg::MODE_REPLY: begin
            if (live) begin
              if (fire) begin
                mask_r[t] <= '0;
                rc_r[t]   <= '0;
              end else if (kind_r[t] == rct_pkg::KIND_EACH && {1'b0, s} < lim) begin
                mask_r[t] <= mask_new;
              end else if (kind_r[t] == rct_pkg::KIND_NTIMES) begin
                rc_r[t] <= rc_inc[15:0];
              end
              if (kind_r[t] == rct_pkg::KIND_GENERAL) begin
                pend_r[t] <= pend_new;
              end
            end
          end
          rct_pkg::MODE_ADD: begin
            if (!live) begin
              valid_r[t] <= 1'b1;
              mask_r[t]  <= '0;
              rc_r[t]    <= '0;
            end
          end
          rct_pkg::MODE_REMOVE: if (live) valid_r[t] <= 1'b0;
          default: ;
        endcase
      end
      if (state_r == ST_SWEEP && sweep_end) begin
        pend_r[t] <= pacc_r + CB'(rem_nz);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_i) begin
      q_r <= in_i;
    end
    if (state_r == ST_EXEC && q_r.mode == rct_pkg::MODE_ADD && !live) begin
      kind_r[t]  <= q_r.kind;
      spawn_r[t] <= q_r.spawn;
      thr_r[t]   <= q_r.count;
    end
    if (state_r == ST_EXEC) begin
      sw_r   <= '0;
      pacc_r <= '0;
    end else if (state_r == ST_SWEEP) begin
      sw_r <= sw_r + CB'(1);
      if (sw_r != '0) begin
        pacc_r <= pacc_r + CB'(rem_nz);
      end
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept_i |-> state_r == ST_IDLE) else $error("Beat accepted while busy.");
  a_exec_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> $past(state_r) == ST_IDLE && $past(accept_i))
    else $error("Execution without an accepted beat.");
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE && state_r != ST_CLEAR |-> pend_r[t] <= CB'(rct_pkg::SOURCES))
    else $error("Pending count out of range.");
  a_sweep_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> sw_r <= CB'(rct_pkg::SOURCES)) else $error("Sweep overran.");

endmodule

>>> hw/rtl/reply_completion_tracker.sv
// ----------------------------------------------------------------------------
// reply_completion_tracker
// Tracks completion conditions of reply types and reports when they fire.
//
//   Channel  Ports                          Beat
//   input    in_valid, in_ready, in_data    one command (rct_pkg::in_t)
//   output   out_valid, out_ready, out_data one result (rct_pkg::out_t)
//
// An item is accepted, then executed against the entry table and
// the remaining-count memory read issued at accept.
// A fire or add of a general condition adds a reload sweep of the
// remaining counts from the expected-count memory.
// After reset a clearing pass zeroes the expected counts; no beat
// is accepted until it ends. A result waiting in the output register does not
// block acceptance while out_ready is high.
// ----------------------------------------------------------------------------
module reply_completion_tracker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rct_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rct_pkg::out_t out_data
);

  rct_pkg::cnt_port_t exp_port;
  rct_pkg::cnt_port_t rem_port;
  rct_pkg::res_t      res;
  logic [7:0]         exp_rdata;
  logic [7:0]         rem_rdata;
  logic               idle;
  logic               accept;
  logic               out_valid_r;
  rct_pkg::out_t      out_data_r;

  assign in_ready  = idle && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rct_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .in_i        (in_data),
    .exp_rdata_i (exp_rdata),
    .rem_rdata_i (rem_rdata),
    .exp_o       (exp_port),
    .rem_o       (rem_port),
    .res_o       (res),
    .idle_o      (idle)
  );

  rct_count_ram u_exp_ram (
    .clk     (clk),
    .port_i  (exp_port),
    .rdata_o (exp_rdata)
  );

  rct_count_ram u_rem_ram (
    .clk     (clk),
    .port_i  (rem_port),
    .rdata_o (rem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.data;
    end
  end

endmodule
